// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the signal extractor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define CSX_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define CSX_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/can_sx_pkg.sv -----
// ----------------------------------------------------------------------------
// can_sx_pkg
// Types, constants and helper functions of the CAN signal extractor.
// ----------------------------------------------------------------------------
package can_sx_pkg;

    localparam int BYTE_BITS = 8;
    localparam int WORD_BITS = 64;
    localparam int PROD_W    = 96;
    localparam int SUM_W     = 97;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_BIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALUE = 3'd5;

    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  length_code;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] physical_value;
        logic [63:0]        raw_field;
        logic               valid_res;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [5:0]         start_bit;
        logic [6:0]         bit_length;
        logic               big_endian;
        logic               is_signed;
        logic signed [31:0] scale_factor;
        logic signed [47:0] offset_value;
    } cfg_t;

    // Extracted field handed from the extractor to the arithmetic pipeline.
    typedef struct packed {
        logic [63:0] raw_field;
        logic        field_ok;
    } field_t;

    // Unsaturated sum handed from the arithmetic pipeline to the output stage.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [63:0]             raw_field;
        logic                    field_ok;
    } acc_t;

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [6:0] n);
        logic [WORD_BITS-1:0] m;
        if (n >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << n[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

// ----- src/can_sx_extract.sv -----
// ----------------------------------------------------------------------------
// can_sx_extract
// Two-stage field extractor: range check and alignment, then field assembly
// in little-endian or big-endian piece order.
// ----------------------------------------------------------------------------
module can_sx_extract
    import can_sx_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output field_t   out_field
);

    localparam int PAYLOAD_BITS = PAYLOAD_BYTES * BYTE_BITS;
    localparam logic [WORD_BITS-1:0] PAY_MASK = low_mask(7'(PAYLOAD_BITS));

    // Stage 1 registers.
    logic                 e1_valid_reg;
    logic [WORD_BITS-1:0] e1_le_reg, e1_le_next;
    logic [WORD_BITS-1:0] e1_be_reg, e1_be_next;
    logic [7:0]           e1_last_reg, e1_last_next;
    logic [3:0]           e1_tail_reg, e1_tail_next;
    logic [5:0]           e1_shift_reg, e1_shift_next;
    logic                 e1_multi_reg, e1_multi_next;
    logic                 e1_ok_reg, e1_ok_next;

    // Stage 2 registers.
    logic   e2_valid_reg;
    field_t e2_field_reg, e2_field_next;

    logic e1_load, e2_load;

    logic [WORD_BITS-1:0] pay_m, pay_swap, swap_sh, top_trim;
    logic [3:0]           byte_cnt;
    logic [7:0]           avail_bits, end_pos, last_pos, head_sum;
    logic [6:0]           head_len;
    logic [8:0]           tail_mask;
    logic [2:0]           s0;

    assign e2_load  = !e2_valid_reg || out_ready;
    assign e1_load  = !e1_valid_reg || e2_load;
    assign in_ready = e1_load;

    always_comb begin
        pay_m    = in_item.payload & PAY_MASK;
        byte_cnt = (in_item.length_code > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES)
                                                             : in_item.length_code;
        avail_bits = {1'b0, byte_cnt, 3'b000};
        end_pos    = {2'b00, cfg.start_bit} + {1'b0, cfg.bit_length};
        last_pos   = end_pos - 8'd1;
        s0         = cfg.start_bit[2:0];
        e1_ok_next = (cfg.bit_length != 7'd0) && (end_pos <= avail_bits);

        // Little-endian field is simply the payload shifted down.
        e1_le_next = pay_m >> cfg.start_bit;

        // Byte-reversed payload with the first field byte on top, then the bits
        // below the start bit inside that byte squeezed out.
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            pay_swap[BYTE_BITS*(7-i) +: BYTE_BITS] = pay_m[BYTE_BITS*i +: BYTE_BITS];
        end
        for (int i = PAYLOAD_BYTES; i < 8; i++) begin
            pay_swap[BYTE_BITS*(7-i) +: BYTE_BITS] = '0;
        end
        swap_sh    = pay_swap << {cfg.start_bit[5:3], 3'b000};
        top_trim   = {swap_sh[63:56] >> s0, swap_sh[55:0]};
        e1_be_next = top_trim << s0;

        // The last piece takes the low bits of the byte holding the last bit.
        e1_tail_next = 4'({1'b0, last_pos[2:0]}) + 4'd1;
        tail_mask    = (9'd1 << e1_tail_next) - 9'd1;
        e1_last_next = pay_m[{last_pos[5:3], 3'b000} +: 8] & tail_mask[7:0];

        head_sum      = {5'b00000, s0} + {1'b0, cfg.bit_length};
        e1_multi_next = head_sum > 8'd8;
        head_len      = cfg.bit_length - {3'b000, e1_tail_next};
        e1_shift_next = 6'(7'd64 - head_len);
    end

    always_comb begin
        e2_field_next.field_ok = e1_ok_reg;
        if (cfg.big_endian && e1_multi_reg) begin
            e2_field_next.raw_field = ((e1_be_reg >> e1_shift_reg) << e1_tail_reg)
                                    | {56'd0, e1_last_reg};
        end else begin
            e2_field_next.raw_field = e1_le_reg & low_mask(cfg.bit_length);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
        end else begin
            if (e1_load) begin
                e1_valid_reg <= in_valid;
            end
            if (e2_load) begin
                e2_valid_reg <= e1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e1_load) begin
            e1_le_reg    <= e1_le_next;
            e1_be_reg    <= e1_be_next;
            e1_last_reg  <= e1_last_next;
            e1_tail_reg  <= e1_tail_next;
            e1_shift_reg <= e1_shift_next;
            e1_multi_reg <= e1_multi_next;
            e1_ok_reg    <= e1_ok_next;
        end
        if (e2_load) begin
            e2_field_reg <= e2_field_next;
        end
    end

    assign out_valid = e2_valid_reg;
    assign out_field = e2_field_reg;

endmodule

// ----- src/can_sx_arith.sv -----
// ----------------------------------------------------------------------------
// can_sx_arith
// Five-stage arithmetic pipeline: sign handling, split multiply, partial
// product sum, sign restore and offset addition.
// ----------------------------------------------------------------------------
module can_sx_arith
    import can_sx_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  field_t in_field,
    output logic   out_valid,
    input  logic   out_ready,
    output acc_t   out_acc
);

    localparam int NSTAGE = 5;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] load;

    // Stage 1: magnitudes and result sign.
    logic [63:0] a1_vmag_reg, a1_vmag_next;
    logic [31:0] a1_smag_reg, a1_smag_next;
    logic        a1_neg_reg, a1_neg_next;
    field_t      a1_field_reg;
    // Stage 2: partial products.
    logic [63:0] a2_pa_reg, a2_pa_next;
    logic [63:0] a2_pb_reg, a2_pb_next;
    logic        a2_neg_reg;
    field_t      a2_field_reg;
    // Stage 3: magnitude of the product.
    logic [PROD_W-1:0] a3_mag_reg, a3_mag_next;
    logic              a3_neg_reg;
    field_t            a3_field_reg;
    // Stage 4: signed product.
    logic signed [PROD_W-1:0] a4_prod_reg, a4_prod_next;
    field_t                   a4_field_reg;
    // Stage 5: product plus offset.
    acc_t a5_acc_reg, a5_acc_next;

    logic        sign_bit;
    logic        scale_neg;
    logic [31:0] scale_u;

    always_comb begin
        load[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end
    assign in_ready = load[0];

    always_comb begin
        sign_bit     = in_field.raw_field[6'(cfg.bit_length - 7'd1)];
        a1_vmag_next = in_field.raw_field;
        if (cfg.is_signed && sign_bit) begin
            a1_vmag_next = (~in_field.raw_field + 64'd1) & low_mask(cfg.bit_length);
        end
        scale_u      = cfg.scale_factor;
        scale_neg    = scale_u[31];
        a1_smag_next = scale_neg ? (~scale_u + 32'd1) : scale_u;
        a1_neg_next  = (cfg.is_signed && sign_bit) != scale_neg;

        a2_pa_next = {32'd0, a1_vmag_reg[31:0]} * {32'd0, a1_smag_reg};
        a2_pb_next = {32'd0, a1_vmag_reg[63:32]} * {32'd0, a1_smag_reg};

        a3_mag_next = {32'd0, a2_pa_reg} + {a2_pb_reg, 32'd0};

        a4_prod_next = a3_neg_reg ? -$signed(a3_mag_reg) : $signed(a3_mag_reg);

        a5_acc_next.sum = {a4_prod_reg[PROD_W-1], a4_prod_reg}
                        + {{(SUM_W-48){cfg.offset_value[47]}}, cfg.offset_value};
        a5_acc_next.raw_field = a4_field_reg.raw_field;
        a5_acc_next.field_ok  = a4_field_reg.field_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (load[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            a1_vmag_reg  <= a1_vmag_next;
            a1_smag_reg  <= a1_smag_next;
            a1_neg_reg   <= a1_neg_next;
            a1_field_reg <= in_field;
        end
        if (load[1]) begin
            a2_pa_reg    <= a2_pa_next;
            a2_pb_reg    <= a2_pb_next;
            a2_neg_reg   <= a1_neg_reg;
            a2_field_reg <= a1_field_reg;
        end
        if (load[2]) begin
            a3_mag_reg   <= a3_mag_next;
            a3_neg_reg   <= a2_neg_reg;
            a3_field_reg <= a2_field_reg;
        end
        if (load[3]) begin
            a4_prod_reg  <= a4_prod_next;
            a4_field_reg <= a3_field_reg;
        end
        if (load[4]) begin
            a5_acc_reg <= a5_acc_next;
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign out_acc   = a5_acc_reg;

endmodule

// ----- src/can_signal_extractor.sv -----
// ----------------------------------------------------------------------------
// can_signal_extractor
// Decodes one configured signal from each CAN frame payload into a saturated
// signed Q47.16 physical value.
// ----------------------------------------------------------------------------
//   Channel   Ports                       Contents
//   input     s_valid s_ready s_item      payload, length_code
//   result    m_valid m_ready m_result    physical_value, raw_field,
//                                         valid_res, saturated
//   config    cfg_wr_en cfg_index         one register write per cycle
//             cfg_wr_data
//
// One frame is accepted per cycle while no stall holds s_ready low; each result
// passes two extraction stages, five arithmetic stages and the output
// register. The multiply is split into two 32x32 partial products.
// Every stage holds its transaction while the stage after it is full, so a
// stall at m_ready fills the bubbles before it reaches s_ready.
// Reset is synchronous; it empties the pipeline and restores the registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module can_signal_extractor
    import can_sx_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_result
);

    localparam logic signed [63:0] VAL_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] VAL_MIN = {1'b1, {63{1'b0}}};

    cfg_t cfg_reg, cfg_next;

    logic   ext_valid, ext_ready;
    field_t ext_field;
    logic   acc_valid, acc_ready;
    acc_t   acc;

    logic      out_valid_reg;
    out_item_t out_reg, out_next;
    logic      out_load;
    logic      sum_fits;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_START_BIT:    cfg_next.start_bit    = cfg_wr_data[5:0];
                REG_BIT_LENGTH:   cfg_next.bit_length   = cfg_wr_data[6:0];
                REG_BIG_ENDIAN:   cfg_next.big_endian   = cfg_wr_data[0];
                REG_IS_SIGNED:    cfg_next.is_signed    = cfg_wr_data[0];
                REG_SCALE_FACTOR: cfg_next.scale_factor = cfg_wr_data[31:0];
                REG_OFFSET_VALUE: cfg_next.offset_value = cfg_wr_data[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_bit    <= 6'd0;
            cfg_reg.bit_length   <= 7'd8;
            cfg_reg.big_endian   <= 1'b0;
            cfg_reg.is_signed    <= 1'b0;
            cfg_reg.scale_factor <= 32'sd65536;
            cfg_reg.offset_value <= 48'sd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    can_sx_extract #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_extract (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .out_valid (ext_valid),
        .out_ready (ext_ready),
        .out_field (ext_field)
    );

    can_sx_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (ext_valid),
        .in_ready  (ext_ready),
        .in_field  (ext_field),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_acc   (acc)
    );

    assign out_load  = !out_valid_reg || m_ready;
    assign acc_ready = out_load;

    // The sum fits in 64 bits when its top bits all copy bit 63.
    always_comb begin
        sum_fits = (&acc.sum[SUM_W-1:63]) || !(|acc.sum[SUM_W-1:63]);
        out_next = '0;
        if (acc.field_ok) begin
            out_next.valid_res = 1'b1;
            out_next.raw_field = acc.raw_field;
            out_next.saturated = !sum_fits;
            if (sum_fits) begin
                out_next.physical_value = acc.sum[63:0];
            end else begin
                out_next.physical_value = acc.sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= acc_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `CSX_ASSERT(a_invalid_zero, aclk, aresetn, (m_valid && !m_result.valid_res) |-> (m_result.physical_value == 64'sd0 && m_result.raw_field == 64'd0 && !m_result.saturated), "invalid transaction carries nonzero fields")
    `CSX_ASSERT(a_sat_clamped, aclk, aresetn, (m_valid && m_result.saturated) |-> (m_result.physical_value == VAL_MAX || m_result.physical_value == VAL_MIN), "saturated value is not a range limit")
    `CSX_ASSERT(a_raw_width, aclk, aresetn, (m_valid && m_result.valid_res) |-> ((m_result.raw_field >> cfg_reg.bit_length) == 64'd0), "raw field wider than configured length")
    `CSX_ASSERT(a_empty_ready, aclk, aresetn, !m_valid |-> s_ready, "input stalled while the output stage is empty")
    `CSX_ASSERT_ALWAYS(a_reset_flush, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule
